### design/sorted_insert_min_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted-insert priority queue
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_INSERT_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SIPQ_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define SIPQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and codes for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  localparam int VALUE_W     = 16;
  localparam int ENTRY_CNT_W = 5;

  // Operation codes of the op field
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic                       push;
    logic                       pop;
    logic signed [VALUE_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

### design/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted chain: compares its entry with the pushed value,
// shifts right on insert and left on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                                  clk,
  input  sipq_pkg::cell_cmd_t                  cmd,
  input  wire  [CNT_W-1:0]                     count,
  input  wire  signed [sipq_pkg::VALUE_W-1:0]  left_entry,
  input  wire                                  left_gt,
  input  wire  signed [sipq_pkg::VALUE_W-1:0]  right_entry,
  output logic signed [sipq_pkg::VALUE_W-1:0]  entry,
  output logic                                 gt
);
  import sipq_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic occupied;
  logic is_tail;

  // Flag a held entry strictly above the pushed value
  assign occupied = count > MY_IDX;
  assign is_tail  = count == MY_IDX;
  assign gt       = occupied && (entry > cmd.value);

  // Take the left neighbor or the new value on push, the right one on pop
  always_ff @(posedge clk) begin
    if (cmd.push && (gt || is_tail)) begin
      entry <= left_gt ? left_entry : cmd.value;
    end else if (cmd.pop) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

### design/sorted_insert_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_min_priority_queue_core
// Bounded min-priority queue of signed 16-bit values held as a sorted chain.
// ----------------------------------------------------------------------------
// One item may be accepted each cycle unless a result waits in the output:
// all QUEUE_DEPTH cells compare their entry with the pushed value at once and
// shift by one slot in the same edge, so the cell compare plus the neighbor
// select sets the clock period. A push places its value behind any equal
// values already held; a pop returns the smallest value. A push on a full
// queue and a pop on an empty one leave the queue unchanged and report an
// error status. Each item gives one result, held in an output register; the
// input stalls while that result waits, and a new item is taken in the same
// cycle the previous result leaves.
`default_nettype none

module sorted_insert_min_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  op,
  input  wire  signed [sipq_pkg::VALUE_W-1:0]  value,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [sipq_pkg::VALUE_W-1:0]  popped_value,
  output logic [1:0]                           status,
  output logic [sipq_pkg::ENTRY_CNT_W-1:0]     entry_count,
  output logic                                 now_empty
);
  import sipq_pkg::*;

  localparam int               CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      fire;
  logic                      full;
  logic                      empty;
  cell_cmd_t                 cmd;
  status_t                   status_next;
  logic signed [VALUE_W-1:0] entries [QUEUE_DEPTH];
  logic                      gts     [QUEUE_DEPTH];

  // Accept while the result register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = count == DEPTH_C;
  assign empty    = count == '0;

  // Build the command for the chain and the next count and status
  always_comb begin
    cmd.push    = fire && (op == OP_PUSH) && !full;
    cmd.pop     = fire && (op == OP_POP) && !empty;
    cmd.value   = value;
    count_next  = count;
    status_next = STATUS_OK;
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
    if (fire && (op == OP_PUSH) && full) begin
      status_next = STATUS_PUSH_FULL;
    end else if (fire && (op == OP_POP) && empty) begin
      status_next = STATUS_POP_EMPTY;
    end
  end

  // Chain of cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry;
    logic                      left_gt;
    logic signed [VALUE_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_gt    = gts[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sipq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
  end

  // Hold the count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result payload with each accepted item
  always_ff @(posedge clk) begin
    if (fire) begin
      popped_value <= cmd.pop ? entries[0] : '0;
      status       <= status_next;
      entry_count  <= ENTRY_CNT_W'(count_next);
      now_empty    <= count_next == '0;
    end
  end

`include "sorted_insert_min_priority_queue_core_assert.svh"

  `SIPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_C, "count above queue depth")
  `SIPQ_ASSERT_NEXT(a_push_grows, cmd.push, count == $past(count) + CNT_W'(1), "push lost")
  `SIPQ_ASSERT_NOW(a_empty_err, out_valid && (status == STATUS_POP_EMPTY), now_empty, "empty")

endmodule

`default_nettype wire

### bench/sorted_insert_min_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_insert_min_priority_queue_core_tb
// Self-checking bench for the sorted-insert min-priority queue. A directed
// table walks the corner cases: pop when empty, the value extremes, equal
// values, filling to capacity and a push when full. Random push/pop bursts
// follow. Each accepted item is run through a behavioral sorted-queue model,
// and every result is compared field by field with the oldest expectation.
// Both sides idle at random. One long receiver stall backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sorted_insert_min_priority_queue_core_tb;
  import sipq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DIR_ROWS     = 24;
  localparam int RAND_BURSTS  = 16;
  localparam int BURST_LEN    = 25;
  localparam int LONG_HOLD    = 80;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped;
    status_t                   st;
    logic [ENTRY_CNT_W-1:0]    cnt;
    logic                      empty;
  } result_t;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] val;
    logic                      chk;
    result_t                   want;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      op;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] popped_value;
  logic [1:0]                status;
  logic [ENTRY_CNT_W-1:0]    entry_count;
  logic                      now_empty;

  // Expected result typed into the table, travels with the item
  logic    fixed_on;
  result_t fixed_result;

  logic signed [VALUE_W-1:0] shadow_queue [$];
  result_t                   pending_results [$];
  int                        mismatch_count = 0;
  int                        in_gap_max = 0;
  int                        out_gap_max = 0;
  bit                        long_hold_req = 1'b0;

  sorted_insert_min_priority_queue_core #(
    .QUEUE_DEPTH (DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count),
    .now_empty    (now_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one item to the shadow sorted list and return its result
  function automatic result_t queue_apply(input logic op_i,
                                          input logic signed [VALUE_W-1:0] v);
    result_t r;
    int      pos;
    int      n;
    r = NO_RESULT;
    r.st = STATUS_OK;
    if (op_i == OP_PUSH) begin
      if (shadow_queue.size() >= DEPTH) begin
        r.st = STATUS_PUSH_FULL;
      end else begin
        // go behind every value that is not larger
        pos = 0;
        while (pos < shadow_queue.size() && shadow_queue[pos] <= v) pos++;
        shadow_queue.insert(pos, v);
      end
    end else if (shadow_queue.size() == 0) begin
      r.st = STATUS_POP_EMPTY;
    end else begin
      r.popped = shadow_queue.pop_front();
    end
    n = shadow_queue.size();
    r.cnt = n[ENTRY_CNT_W-1:0];
    r.empty = (n == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got_v, input int want_v);
    if (mismatch_count < 40)
      $display("%0t: %s mismatch: got %0d, want %0d", $realtime, field, got_v, want_v);
    mismatch_count++;
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic op_i, input logic signed [VALUE_W-1:0] v,
                           input logic chk, input result_t want);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= op_i;
    value        <= v;
    fixed_on     <= chk;
    fixed_result <= want;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
  endtask

  // Check results first, then log newly accepted items
  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t next_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, popped_value", int'(popped_value), 0);
        end else begin
          want = pending_results.pop_front();
          if (popped_value !== want.popped)
            report_mismatch("popped_value", int'(popped_value), int'(want.popped));
          if (status !== want.st)
            report_mismatch("status", int'(status), int'(want.st));
          if (entry_count !== want.cnt)
            report_mismatch("entry_count", int'(entry_count), int'(want.cnt));
          if (now_empty !== want.empty)
            report_mismatch("now_empty", int'(now_empty), int'(want.empty));
        end
      end
      if (in_valid && in_ready) begin
        next_r = queue_apply(op, value);
        if (fixed_on) next_r = fixed_result;
        pending_results.push_back(next_r);
      end
    end
  end

  // Receiver: random stall per result, one long hold on request
  initial begin : sink
    int gap;
    out_ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle = 0;
      else idle++;
    end
    $display("[sorted_insert_min_priority_queue_core] ERROR");
    $finish;
  end

  initial begin : main
    dir_row_t                  dir_rows [DIR_ROWS];
    int                        push_pct;
    logic                      rop;
    logic signed [VALUE_W-1:0] rval;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= OP_PUSH;
    value        <= '0;
    fixed_on     <= 1'b0;
    fixed_result <= NO_RESULT;

    dir_rows = '{
      // pop when empty right after reset
      '{OP_POP,  16'sd0,     1'b1, '{16'sd0, STATUS_POP_EMPTY, 5'd0, 1'b1}},
      '{OP_PUSH, 16'sh7FFF,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sh8000,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd0,     1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd0,     1'b0, NO_RESULT},
      '{OP_PUSH, -16'sd1,    1'b0, NO_RESULT},
      // most negative value leaves first
      '{OP_POP,  16'sd0,     1'b1, '{16'sh8000, STATUS_OK, 5'd4, 1'b0}},
      '{OP_POP,  16'sh1234,  1'b0, NO_RESULT},
      // fill to capacity, with extremes and repeated values
      '{OP_PUSH, 16'sh8000,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sh7FFF,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd1,     1'b0, NO_RESULT},
      '{OP_PUSH, -16'sd2,    1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd0,     1'b0, NO_RESULT},
      '{OP_PUSH, 16'sh5555,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'shAAAA,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd7,     1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd7,     1'b0, NO_RESULT},
      '{OP_PUSH, 16'sh8001,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sh7FFE,  1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd0,     1'b0, NO_RESULT},
      '{OP_PUSH, 16'sd100,   1'b0, NO_RESULT},
      // push when full is dropped
      '{OP_PUSH, 16'sd5,     1'b1, '{16'sd0, STATUS_PUSH_FULL, 5'd16, 1'b0}},
      '{OP_POP,  16'shFFFF,  1'b1, '{16'sh8000, STATUS_OK, 5'd15, 1'b0}},
      '{OP_POP,  16'sd0,     1'b0, NO_RESULT}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, no idling on either side
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].chk, dir_rows[i].want);
    end

    // Random bursts, each with its own push mix and idling mode
    for (int b = 0; b < RAND_BURSTS; b++) begin
      case ($urandom_range(0, 4))
        0: push_pct = 90;
        1: push_pct = 10;
        2: push_pct = 50;
        3: push_pct = 97;
        default: push_pct = 3;
      endcase
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      // back up the block: receiver stalls while items keep coming
      if (b == 2) begin
        push_pct      = 90;
        in_gap_max    = 0;
        long_hold_req = 1'b1;
      end
      for (int k = 0; k < BURST_LEN; k++) begin
        rop = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
        case ($urandom_range(0, 3))
          0: rval = VALUE_W'(int'($urandom_range(0, 8)) - 4);
          1: rval = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          default: rval = VALUE_W'($urandom);
        endcase
        send_item(rop, rval, 1'b0, NO_RESULT);
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sorted_insert_min_priority_queue_core] OK");
    end else begin
      $display("[sorted_insert_min_priority_queue_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sorted_insert_min_priority_queue_core.f
+incdir+design
design/sipq_pkg.sv
design/sipq_cell.sv
design/sorted_insert_min_priority_queue_core.sv
bench/sorted_insert_min_priority_queue_core_tb.sv
